FILE: src/tcdt_pkg.sv
package tcdt_pkg;

	localparam logic [7:0]         CRC_POLY     = 8'h31;
	localparam logic [14:0]        SCALE_NUM    = 15'd17572;
	localparam logic signed [15:0] OFFSET_CENTI = 16'sd4685;
	// floor(x / 100) == (x * 5243) >> 19 for x below 43690
	localparam logic [12:0]        RECIP_100    = 13'd5243;
	localparam int                 RECIP_SHIFT  = 19;
	localparam logic signed [14:0] TEMP_MIN     = -15'sd4685;
	localparam logic signed [14:0] TEMP_MAX     = 15'sd12886;
	localparam logic signed [14:0] REF_RESET    = 15'sd0;
	localparam logic signed [8:0]  STEP_MIN     = -9'sd256;
	localparam logic signed [8:0]  STEP_MAX     = 9'sd255;

	typedef struct packed {
		logic [15:0] raw_code;
		logic [7:0]  received_crc;
		logic        check_enable;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature;
		logic               crc_error;
	} conv_t;

	typedef struct packed {
		logic signed [14:0] temperature;
		logic               crc_error;
		logic [8:0]         whole_mag;
		logic               whole_neg;
	} scaled_t;

	// CRC-8, MSB first, zero init, high byte of the code first
	function automatic logic [7:0] crc8(input logic [15:0] code);
		logic [7:0] crc;
		logic       fb;
		crc = '0;
		for (int i = 15; i >= 0; i--) begin
			fb  = crc[7] ^ code[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	function automatic logic signed [8:0] sat9(input logic signed [9:0] v);
		logic signed [8:0] r;
		if (v < 10'sd0 - 10'sd256) begin
			r = STEP_MIN;
		end else if (v > 10'sd255) begin
			r = STEP_MAX;
		end else begin
			r = v[8:0];
		end
		return r;
	endfunction

endpackage

FILE: src/tcdt_conv.sv
module tcdt_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcdt_pkg::sample_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tcdt_pkg::conv_t   out_data
);

	logic [30:0]        prod;
	logic signed [15:0] temp_w;
	logic               mismatch;
	logic               valid_q;
	tcdt_pkg::conv_t    data_s2;

	assign prod     = 31'(in_data.raw_code) * 31'(tcdt_pkg::SCALE_NUM);
	assign temp_w   = $signed({1'b0, prod[30:16]}) - tcdt_pkg::OFFSET_CENTI;
	assign mismatch = tcdt_pkg::crc8(in_data.raw_code) != in_data.received_crc;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.temperature <= temp_w[14:0];
			data_s2.crc_error   <= in_data.check_enable && mismatch;
		end
	end

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (data_s2.temperature >= tcdt_pkg::TEMP_MIN &&
			data_s2.temperature <= tcdt_pkg::TEMP_MAX))
		else $error("converted temperature out of range");

endmodule

FILE: src/tcdt_scale.sv
module tcdt_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [14:0] ref_level,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcdt_pkg::conv_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tcdt_pkg::scaled_t  out_data
);

	logic signed [15:0] diff;
	logic [15:0]        mag;
	logic [27:0]        prod;
	logic               valid_q;
	tcdt_pkg::scaled_t  data_s3;

	assign diff = $signed({in_data.temperature[14], in_data.temperature})
		- $signed({ref_level[14], ref_level});
	assign mag  = diff[15] ? 16'(-diff) : 16'(diff);
	assign prod = 28'(mag[14:0]) * 28'(tcdt_pkg::RECIP_100);

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3.temperature <= in_data.temperature;
			data_s3.crc_error   <= in_data.crc_error;
			data_s3.whole_mag   <= prod[tcdt_pkg::RECIP_SHIFT +: 9];
			data_s3.whole_neg   <= diff[15];
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(data_s3))
		else $error("scaled item changed while stalled");

endmodule

FILE: src/tcdt_track.sv
module tcdt_track (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcdt_pkg::scaled_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] temperature,
	output logic               crc_error,
	output logic signed [8:0]  degree_steps
);

	logic signed [9:0] whole_w;
	logic signed [8:0] whole9;
	logic signed [9:0] steps_w;
	logic              valid_q;
	logic signed [8:0] last_q;
	logic signed [14:0] temperature_q;
	logic              crc_error_q;
	logic signed [8:0] degree_steps_q;
	logic              fire;

	assign whole_w = in_data.whole_neg ? -$signed({1'b0, in_data.whole_mag})
		: $signed({1'b0, in_data.whole_mag});
	assign whole9  = tcdt_pkg::sat9(whole_w);
	assign steps_w = $signed({whole9[8], whole9}) - $signed({last_q[8], last_q});

	assign in_ready     = !valid_q || out_ready;
	assign fire         = in_ready && in_valid;
	assign out_valid    = valid_q;
	assign temperature  = temperature_q;
	assign crc_error    = crc_error_q;
	assign degree_steps = degree_steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (fire) begin
				last_q <= whole9;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			temperature_q  <= in_data.temperature;
			crc_error_q    <= in_data.crc_error;
			degree_steps_q <= tcdt_pkg::sat9(steps_w);
		end
	end

	a_steps_track: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (9'(degree_steps_q + $past(last_q)) == last_q ||
			degree_steps_q == tcdt_pkg::STEP_MIN || degree_steps_q == tcdt_pkg::STEP_MAX))
		else $error("degree steps disagree with stored difference");

endmodule

FILE: src/temp_code_convert_degree_tracker_unit.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tdata: raw_code, received_crc; tuser: check_enable
// m_        out  m_tvalid/m_tready    tdata: temperature, degree_steps; tuser: crc_error
// cfg_      in   cfg_valid/cfg_ready  cfg_data: reference_temperature
//
// One item per cycle sustained while m_tready is high. Four registers in order: input reg,
// CRC/scale multiply, divide-by-100 multiply, tracker (the output register).
// arst_n clears stage valids, the stored whole-degree difference and the reference.
// Each stage holds while the next is full and stalled; bubbles still fill,
// so s_tready drops only when all stages hold items and m_tready is low.
module temp_code_convert_degree_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] raw_code, [23:16] received_crc
	input  logic        s_tuser,  // [0] check_enable
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [14:0] temperature, [23:15] degree_steps
	output logic        m_tuser,  // [0] crc_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	logic signed [14:0] ref_q;
	logic               valid_s1;
	tcdt_pkg::sample_t  sample_s1;
	logic               conv_in_ready;
	logic               conv_valid;
	tcdt_pkg::conv_t    conv_data;
	logic               scale_in_ready;
	logic               scale_valid;
	tcdt_pkg::scaled_t  scale_data;
	logic               track_in_ready;
	logic signed [14:0] temperature;
	logic               crc_error;
	logic signed [8:0]  degree_steps;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1 || conv_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q    <= tcdt_pkg::REF_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ref_q <= $signed(cfg_data);
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1.raw_code     <= s_tdata[15:0];
			sample_s1.received_crc <= s_tdata[23:16];
			sample_s1.check_enable <= s_tuser;
		end
	end

	tcdt_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (conv_in_ready),
		.in_data   (sample_s1),
		.out_valid (conv_valid),
		.out_ready (scale_in_ready),
		.out_data  (conv_data)
	);

	tcdt_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.ref_level (ref_q),
		.in_valid  (conv_valid),
		.in_ready  (scale_in_ready),
		.in_data   (conv_data),
		.out_valid (scale_valid),
		.out_ready (track_in_ready),
		.out_data  (scale_data)
	);

	tcdt_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (scale_valid),
		.in_ready     (track_in_ready),
		.in_data      (scale_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.temperature  (temperature),
		.crc_error    (crc_error),
		.degree_steps (degree_steps)
	);

	assign m_tdata = {degree_steps, temperature};
	assign m_tuser = crc_error;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [7:0]  CRC_POLY_LO = 8'h31;
	localparam int          SCALE_NUM   = 17572;
	localparam int          OFFSET      = 4685;
	localparam int          HOLD_CYCLES = 300;
	localparam int          PER_SETTING = 100;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH,
		IDLE_PRESSURE
	} idle_mode_e;

	typedef struct {
		logic signed [14:0] temperature;
		logic               crc_error;
		logic signed [8:0]  degree_steps;
	} reading_t;

	class conv_scoreboard;
		logic signed [14:0] ref_centi;
		logic signed [8:0]  prev_whole;
		reading_t           expected_q[$];
		int                 errors;
		int                 checked;

		function new();
			ref_centi  = '0;
			prev_whole = '0;
			errors     = 0;
			checked    = 0;
		endfunction

		static function logic [7:0] crc_of(logic [15:0] code);
			logic [7:0] c;
			c = 8'h00;
			for (int b = 1; b >= 0; b--) begin
				c ^= code[b*8 +: 8];
				for (int k = 0; k < 8; k++) begin
					c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY_LO) : {c[6:0], 1'b0};
				end
			end
			return c;
		endfunction

		static function int clamp9(int v);
			if (v < -256) begin
				return -256;
			end
			if (v > 255) begin
				return 255;
			end
			return v;
		endfunction

		function void set_reference(logic [14:0] v);
			ref_centi = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_reading(logic [15:0] code, logic [7:0] rcrc, logic chk);
			int       temp;
			int       whole;
			int       steps;
			reading_t r;
			temp  = ((SCALE_NUM * int'(code)) >>> 16) - OFFSET;
			// int division truncates toward zero
			whole = clamp9((temp - int'(ref_centi)) / 100);
			steps = clamp9(whole - int'(prev_whole));
			prev_whole = whole[8:0];
			r.temperature  = temp[14:0];
			r.crc_error    = chk && (crc_of(code) != rcrc);
			r.degree_steps = steps[8:0];
			expected_q.push_back(r);
		endfunction

		function void check_reading(logic [23:0] data, logic flag);
			reading_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected item: temperature %0d", $signed(data[14:0]));
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (data[14:0] !== e.temperature) begin
				$error("temperature: expected %0d, actual %0d",
					e.temperature, $signed(data[14:0]));
				errors++;
			end
			if (flag !== e.crc_error) begin
				$error("crc_error: expected %0d, actual %0d", e.crc_error, flag);
				errors++;
			end
			if (data[23:15] !== e.degree_steps) begin
				$error("degree_steps: expected %0d, actual %0d",
					e.degree_steps, $signed(data[23:15]));
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data  = '0;

	idle_mode_e     idle_mode = IDLE_NONE;
	logic           hold_off  = 1'b0;
	conv_scoreboard sb        = new();
	int             readings_sent;
	int             crc_checked;
	int             ref_settings;

	temp_code_convert_degree_tracker_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int sender_idle_pct();
		return (idle_mode == IDLE_SENDER) ? 49 : (idle_mode == IDLE_BOTH) ? 20 : 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_reading(m_tdata, m_tuser);
		end
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (idle_mode == IDLE_RECEIVER) begin
			m_tready <= !chance(49);
		end else if (idle_mode == IDLE_BOTH) begin
			m_tready <= !chance(20);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("temp_code_convert_degree_tracker_unit: mismatch");
		$finish;
	end

	task automatic send_reading(input logic [15:0] code, input logic [7:0] crc,
			input logic chk);
		if (chance(sender_idle_pct())) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (chance(sender_idle_pct()));
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {crc, code};
		s_tuser  <= chk;
		do @(posedge clk); while (!s_tready);
		sb.note_reading(code, crc, chk);
		readings_sent++;
		crc_checked += chk;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reference(input logic [14:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reference(v);
		ref_settings++;
	endtask

	initial begin
		logic [15:0] code;
		logic [15:0] drift_code;
		logic [7:0]  crc;
		logic        chk;
		logic [14:0] ref_vals[10];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset reference (zero): field extremes, CRC cases, truncation near zero
		send_reading(16'h0000, conv_scoreboard::crc_of(16'h0000), 1'b1);
		send_reading(16'hFFFF, conv_scoreboard::crc_of(16'hFFFF), 1'b1);
		send_reading(16'hFFFF, ~conv_scoreboard::crc_of(16'hFFFF), 1'b1);
		send_reading(16'h8000, 8'hFF, 1'b0);
		send_reading(16'h7FFF, 8'h00, 1'b1);
		send_reading(16'h0001, conv_scoreboard::crc_of(16'h0001), 1'b1);
		send_reading(16'h5555, 8'hAA, 1'b1);
		send_reading(16'hAAAA, conv_scoreboard::crc_of(16'hAAAA), 1'b0);
		send_reading(16'd16913, 8'h55, 1'b1);
		send_reading(16'd16900, conv_scoreboard::crc_of(16'd16900), 1'b1);
		send_reading(16'd17300, 8'h00, 1'b0);
		send_reading(16'd17480, 8'h01, 1'b1);
		// out-of-range references: saturated difference and saturated steps
		write_reference(15'h4000);
		send_reading(16'hFFFF, 8'h00, 1'b0);
		write_reference(15'h3FFF);
		send_reading(16'h0000, 8'h00, 1'b0);
		write_reference(15'h4000);
		send_reading(16'hFFFF, 8'h00, 1'b0);
		send_reading(16'h0000, 8'h00, 1'b0);

		ref_vals[0] = 15'(-4685);
		ref_vals[1] = 15'(12886);
		ref_vals[2] = 15'h4000;
		ref_vals[3] = 15'h3FFF;
		ref_vals[4] = 15'($urandom_range(0, 17571) - 4685);
		ref_vals[5] = 15'($urandom);
		ref_vals[6] = 15'(2000);
		ref_vals[7] = 15'(-1000);
		ref_vals[8] = 15'($urandom_range(0, 17571) - 4685);
		ref_vals[9] = 15'($urandom);

		drift_code = 16'($urandom);
		for (int s = 0; s < 10; s++) begin
			write_reference(ref_vals[s]);
			idle_mode = idle_mode_e'(s / 2);
			if (s == 8) begin
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			for (int i = 0; i < PER_SETTING; i++) begin
				// mostly slow drift so small steps dominate, some jumps
				if ($urandom_range(0, 9) < 6) begin
					drift_code = drift_code + 16'($urandom_range(0, 1200)) - 16'd600;
				end else begin
					drift_code = 16'($urandom);
				end
				code = drift_code;
				chk  = 1'($urandom_range(0, 1));
				crc  = $urandom_range(0, 1) ? conv_scoreboard::crc_of(code) : 8'($urandom);
				send_reading(code, crc, chk);
			end
		end

		idle_mode = IDLE_NONE;
		drain();
		repeat (10) @(posedge clk);

		$display("%0d readings sent (%0d with CRC check) under %0d reference settings;",
			readings_sent, crc_checked, ref_settings);
		$display("%0d results checked, idle and stall phases plus one %0d-cycle output hold",
			sb.checked, HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("temp_code_convert_degree_tracker_unit: match");
		end else begin
			$display("temp_code_convert_degree_tracker_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: temp_code_convert_degree_tracker_unit.f
src/tcdt_pkg.sv
src/tcdt_conv.sv
src/tcdt_scale.sv
src/tcdt_track.sv
src/temp_code_convert_degree_tracker_unit.sv
tb/sv/tb_top.sv
